[hw/rtl/rle_pkg.sv]
package rle_pkg;

    localparam int MAX_LITERAL = 128;
    localparam int MAX_REPEAT  = 129;
    localparam int OUT_BYTES   = 8;

    localparam int OUT_W  = 8 * OUT_BYTES;
    localparam int LIT_AW = (MAX_LITERAL > 2) ? $clog2(MAX_LITERAL) : 1;
    localparam int CNT_W  = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_LIT  = 2'd1;
    localparam logic [1:0] MODE_REP  = 2'd2;

    // header byte and data byte of a two-byte packet
    typedef struct packed {
        logic [7:0] hdr;
        logic [7:0] val;
    } rle_pair_t;

    function automatic logic [7:0] rep_header(input logic [7:0] c);
        logic [7:0] h;
        if (c < 8'd2)
        begin
            h = 8'd128;
        end
        else
        begin
            h = c + 8'd126;
        end
        return h;
    endfunction

endpackage

[hw/rtl/rle_in_if.sv]
interface rle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

[hw/rtl/rle_out_if.sv]
interface rle_out_if;
    logic                     valid;
    logic                     ready;
    logic [rle_pkg::OUT_W-1:0] out_bytes;
    logic [3:0]               out_count;
    logic                     run_last;

    modport source (output valid, output out_bytes, output out_count, output run_last,
                    input ready);
    modport sink   (input valid, input out_bytes, input out_count, input run_last,
                    output ready);
endinterface

[hw/rtl/rle_literal_repeat_encoder.sv]
// Run-length encoder, literal/repeat packet scheme.
// din takes one byte per request with stream_end on the final byte of a stream.
// dout gives packed words: up to eight encoded bytes, first byte in bits 7:0,
// out_count valid bytes, run_last on the final word caused by one input byte.
// An input byte that closes no packet is taken and gives no word.
// An input byte that closes packets is taken, then its packets are emitted byte
// by byte: a literal of n bytes emits n+1 bytes, read one per cycle from the
// literal store RAM while dout does not stall; a repeat packet emits two. The
// worst case is 129 bytes (17 words). din.ready is low while packets are
// emitted. Bytes are gathered in the packer register and each word is then
// held in the output register for dout. The output register decouples the two
// sides: a new byte is taken while a finished word waits. When dout stalls with
// a word held, emission pauses until that word is taken.
// Reset (rst_n low) returns to idle with no open run and no pending output;
// the literal store needs no clearing since only written entries are read.
module rle_literal_repeat_encoder (
    input  logic       clk,
    input  logic       rst_n,
    rle_in_if.sink     din,
    rle_out_if.source  dout
);
    import rle_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LHDR  = 3'd1;
    localparam logic [2:0] ST_LBODY = 3'd2;
    localparam logic [2:0] ST_PAH   = 3'd3;
    localparam logic [2:0] ST_PAV   = 3'd4;
    localparam logic [2:0] ST_PBH   = 3'd5;
    localparam logic [2:0] ST_PBV   = 3'd6;

    // encoder state
    logic [1:0] mode_reg, mode_next;
    logic [7:0] lit_len_reg, lit_len_next;
    logic [7:0] rep_val_reg, rep_val_next;
    logic [7:0] rep_len_reg, rep_len_next;
    logic [7:0] prev_reg, prev_next;

    // emission sequencer
    logic [2:0]        state_reg, state_next;
    logic              lit_v_reg, lit_v_next;
    logic [7:0]        lhdr_reg, lhdr_next;
    logic [LIT_AW-1:0] idx_reg, idx_next;
    rle_pair_t         pa_reg, pa_next;
    logic              pa_v_reg, pa_v_next;
    rle_pair_t         pb_reg, pb_next;
    logic              pb_v_reg, pb_v_next;

    // packer and output register
    logic [OUT_W-1:0] pack_reg, pack_next;
    logic [CNT_W-1:0] pack_cnt_reg, pack_cnt_next;
    logic [OUT_W-1:0] out_bytes_reg, out_bytes_next;
    logic [3:0]       out_count_reg, out_count_next;
    logic             run_last_reg, run_last_next;
    logic             out_valid_reg, out_valid_next;

    logic              accept;
    logic              advance;
    logic              emit;
    logic              emit_final;
    logic [7:0]        emit_byte;
    logic              wr_en;
    logic [LIT_AW-1:0] wr_addr;
    logic              rd_en;
    logic [LIT_AW-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic [7:0]        len_inc;
    logic [7:0]        rl_inc;
    logic [OUT_W-1:0]  word;

    assign din.ready = (state_reg == ST_IDLE);
    assign accept    = din.valid && din.ready;
    assign advance   = !out_valid_reg || dout.ready;

    rle_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LITERAL)
    ) u_lit_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (din.in_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // run tracking on an accepted byte
    always_comb
    begin
        mode_next    = mode_reg;
        lit_len_next = lit_len_reg;
        rep_val_next = rep_val_reg;
        rep_len_next = rep_len_reg;
        prev_next    = prev_reg;
        lit_v_next   = lit_v_reg;
        lhdr_next    = lhdr_reg;
        pa_next      = pa_reg;
        pa_v_next    = pa_v_reg;
        pb_next      = pb_reg;
        pb_v_next    = pb_v_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        len_inc      = lit_len_reg + 8'd1;
        rl_inc       = rep_len_reg + 8'd1;
        if (accept)
        begin
            lit_v_next = 1'b0;
            pa_v_next  = 1'b0;
            pb_v_next  = 1'b0;
            case (mode_reg)
                MODE_LIT:
                begin
                    if (din.in_byte == prev_reg)
                    begin
                        // flush all but the matching byte, the pair opens a repeat
                        if (lit_len_reg > 8'd1)
                        begin
                            lit_v_next = 1'b1;
                            lhdr_next  = lit_len_reg - 8'd2;
                        end
                        mode_next    = MODE_REP;
                        rep_val_next = din.in_byte;
                        rep_len_next = 8'd2;
                        lit_len_next = 8'd0;
                        if ((MAX_REPEAT <= 2) || din.stream_end)
                        begin
                            pa_next      = '{hdr: rep_header(8'd2), val: din.in_byte};
                            pa_v_next    = 1'b1;
                            mode_next    = MODE_IDLE;
                            rep_len_next = 8'd0;
                        end
                    end
                    else
                    begin
                        wr_en        = 1'b1;
                        wr_addr      = lit_len_reg[LIT_AW-1:0];
                        lit_len_next = len_inc;
                        prev_next    = din.in_byte;
                        if ((len_inc >= 8'(MAX_LITERAL)) || din.stream_end)
                        begin
                            lit_v_next   = 1'b1;
                            lhdr_next    = lit_len_reg;
                            mode_next    = MODE_IDLE;
                            lit_len_next = 8'd0;
                            rep_len_next = 8'd0;
                        end
                    end
                end
                MODE_REP:
                begin
                    if (din.in_byte == rep_val_reg)
                    begin
                        rep_len_next = rl_inc;
                        if ((rl_inc >= 8'(MAX_REPEAT)) || din.stream_end)
                        begin
                            pa_next      = '{hdr: rep_header(rl_inc), val: rep_val_reg};
                            pa_v_next    = 1'b1;
                            mode_next    = MODE_IDLE;
                            lit_len_next = 8'd0;
                            rep_len_next = 8'd0;
                        end
                    end
                    else
                    begin
                        pa_next      = '{hdr: rep_header(rep_len_reg), val: rep_val_reg};
                        pa_v_next    = 1'b1;
                        wr_en        = 1'b1;
                        wr_addr      = '0;
                        prev_next    = din.in_byte;
                        mode_next    = MODE_LIT;
                        lit_len_next = 8'd1;
                        rep_len_next = 8'd0;
                        if (din.stream_end)
                        begin
                            pb_next      = '{hdr: 8'd0, val: din.in_byte};
                            pb_v_next    = 1'b1;
                            mode_next    = MODE_IDLE;
                            lit_len_next = 8'd0;
                        end
                    end
                end
                default:
                begin
                    wr_en        = 1'b1;
                    wr_addr      = '0;
                    prev_next    = din.in_byte;
                    mode_next    = MODE_LIT;
                    lit_len_next = 8'd1;
                    rep_len_next = 8'd0;
                    if (din.stream_end)
                    begin
                        pa_next      = '{hdr: 8'd0, val: din.in_byte};
                        pa_v_next    = 1'b1;
                        mode_next    = MODE_IDLE;
                        lit_len_next = 8'd0;
                    end
                end
            endcase
        end
    end

    // byte sequencer: literal header, literal body from RAM, then up to two pairs
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        emit       = 1'b0;
        emit_final = 1'b0;
        emit_byte  = 8'd0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (lit_v_next)
                    begin
                        state_next = ST_LHDR;
                    end
                    else if (pa_v_next)
                    begin
                        state_next = ST_PAH;
                    end
                end
            end
            ST_LHDR:
            begin
                emit      = advance;
                emit_byte = lhdr_reg;
                if (advance)
                begin
                    // prefetch the first stored byte
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    state_next = ST_LBODY;
                end
            end
            ST_LBODY:
            begin
                emit      = advance;
                emit_byte = rd_data;
                if (idx_reg == lhdr_reg[LIT_AW-1:0])
                begin
                    emit_final = advance && !pa_v_reg;
                    if (advance)
                    begin
                        state_next = pa_v_reg ? ST_PAH : ST_IDLE;
                    end
                end
                else if (advance)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + LIT_AW'(1);
                    idx_next = idx_reg + LIT_AW'(1);
                end
            end
            ST_PAH:
            begin
                emit      = advance;
                emit_byte = pa_reg.hdr;
                if (advance)
                begin
                    state_next = ST_PAV;
                end
            end
            ST_PAV:
            begin
                emit       = advance;
                emit_byte  = pa_reg.val;
                emit_final = advance && !pb_v_reg;
                if (advance)
                begin
                    state_next = pb_v_reg ? ST_PBH : ST_IDLE;
                end
            end
            ST_PBH:
            begin
                emit      = advance;
                emit_byte = pb_reg.hdr;
                if (advance)
                begin
                    state_next = ST_PBV;
                end
            end
            ST_PBV:
            begin
                emit       = advance;
                emit_byte  = pb_reg.val;
                emit_final = advance;
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pack bytes into words, push on a full word or the final byte
    always_comb
    begin
        word           = pack_reg;
        pack_next      = pack_reg;
        pack_cnt_next  = pack_cnt_reg;
        out_bytes_next = out_bytes_reg;
        out_count_next = out_count_reg;
        run_last_next  = run_last_reg;
        out_valid_next = out_valid_reg && !dout.ready;
        word[8 * pack_cnt_reg +: 8] = emit_byte;
        if (emit)
        begin
            if ((pack_cnt_reg == CNT_W'(OUT_BYTES - 1)) || emit_final)
            begin
                out_bytes_next = word;
                out_count_next = 4'(pack_cnt_reg) + 4'd1;
                run_last_next  = emit_final;
                out_valid_next = 1'b1;
                pack_next      = '0;
                pack_cnt_next  = '0;
            end
            else
            begin
                pack_next     = word;
                pack_cnt_next = pack_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            lit_len_reg   <= 8'd0;
            rep_val_reg   <= 8'd0;
            rep_len_reg   <= 8'd0;
            prev_reg      <= 8'd0;
            state_reg     <= ST_IDLE;
            lit_v_reg     <= 1'b0;
            pa_v_reg      <= 1'b0;
            pb_v_reg      <= 1'b0;
            pack_reg      <= '0;
            pack_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            lit_len_reg   <= lit_len_next;
            rep_val_reg   <= rep_val_next;
            rep_len_reg   <= rep_len_next;
            prev_reg      <= prev_next;
            state_reg     <= state_next;
            lit_v_reg     <= lit_v_next;
            pa_v_reg      <= pa_v_next;
            pb_v_reg      <= pb_v_next;
            pack_reg      <= pack_next;
            pack_cnt_reg  <= pack_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lhdr_reg      <= lhdr_next;
        idx_reg       <= idx_next;
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        out_bytes_reg <= out_bytes_next;
        out_count_reg <= out_count_next;
        run_last_reg  <= run_last_next;
    end

    assign dout.valid     = out_valid_reg;
    assign dout.out_bytes = out_bytes_reg;
    assign dout.out_count = out_count_reg;
    assign dout.run_last  = run_last_reg;
endmodule

[hw/rtl/rle_ram.sv]
module rle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
